@@ rtl/lpurs_pkg.sv @@
// shared types and constants of the lock-pin unlock ramp sequencer
// used by lpurs_ctrl, lpurs_dp and lock_pin_unlock_ramp_sequencer; no dependencies
package lpurs_pkg;

  // field widths
  localparam int CMD_W   = 10;
  localparam int TICK_W  = 8;
  localparam int IDX_W   = 3;
  localparam int PHASE_W = 3;

  // command and counter limits
  localparam logic [CMD_W-1:0]  CMD_MAX = 10'd1023;
  localparam logic [TICK_W-1:0] CNT_MAX = 8'd255;

  // ramp arithmetic widths
  localparam int DIFF_W = CMD_W + 1;             // slope_end - slope_start
  localparam int NUM_W  = TICK_W + 1;            // stepped timer - init_time
  localparam int PROD_W = DIFF_W + NUM_W;        // signed product
  localparam int DVD_W  = CMD_W + TICK_W;        // product magnitude
  localparam int SUM_W  = DVD_W + 2;             // signed quotient plus offset
  localparam int DIV_STEPS = DVD_W;              // one quotient bit per cycle
  localparam int STEP_W = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_INIT_TIME    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLOPE_TIME   = 3'd1;
  localparam logic [IDX_W-1:0] REG_STAB_TIME    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ATTEMPT_THR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INIT_CMD     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOPE_START  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SLOPE_END    = 3'd6;
  localparam logic [IDX_W-1:0] REG_STAB_CMD     = 3'd7;

  // sequence phases
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_INIT = 3'd1,
    PH_RAMP = 3'd2,
    PH_STAB = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DEC  = 3'd1,
    ST_LOAD = 3'd2,
    ST_DIV  = 3'd3,
    ST_DONE = 3'd4
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_en;
    logic mul_load;
    logic div_load;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_ramp;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/lpurs_ctrl.sv @@
// controller state machine of the unlock ramp sequencer
// depends on lpurs_pkg; drives the datapath lpurs_dp through dp_cmd_t
module lpurs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpurs_pkg::dp_sts_t sts,
  output lpurs_pkg::dp_cmd_t cmd
);

  lpurs_pkg::ctrl_state_t state_r, state_nxt;
  logic [lpurs_pkg::STEP_W-1:0] step_r, step_nxt;

  // state and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpurs_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      lpurs_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_en = in_valid;
        if (in_valid) state_nxt = lpurs_pkg::ST_DEC;
      end
      lpurs_pkg::ST_DEC: begin
        cmd.mul_load = 1'b1;
        state_nxt = sts.need_ramp ? lpurs_pkg::ST_LOAD : lpurs_pkg::ST_DONE;
      end
      lpurs_pkg::ST_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = lpurs_pkg::STEP_W'(lpurs_pkg::DIV_STEPS - 1);
        state_nxt    = lpurs_pkg::ST_DIV;
      end
      lpurs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) state_nxt = lpurs_pkg::ST_DONE;
        else step_nxt = step_r - 1'b1;
      end
      lpurs_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = lpurs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpurs_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/lpurs_dp.sv @@
// datapath of the unlock ramp sequencer: config registers, sequence state,
// ramp multiplier, iterative divider and output register; depends on lpurs_pkg
module lpurs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpurs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [lpurs_pkg::CMD_W-1:0]         cfg_wdata,
  input  logic                                in_unlock_enable,
  input  lpurs_pkg::dp_cmd_t                  cmd,
  output lpurs_pkg::dp_sts_t                  sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpurs_pkg::CMD_W-1:0]         out_drive_command,
  output logic                                out_end_flag,
  output logic [lpurs_pkg::PHASE_W-1:0]       out_phase_code,
  output logic [lpurs_pkg::TICK_W-1:0]        out_phase_ticks,
  output logic [lpurs_pkg::TICK_W-1:0]        out_attempts_done,
  output logic                                out_phase_fault
);

  localparam int CW = lpurs_pkg::CMD_W;
  localparam int TW = lpurs_pkg::TICK_W;

  // configuration registers
  logic [TW-1:0] init_time_r, slope_time_r, stab_time_r, attempt_thr_r;
  logic [CW-1:0] init_cmd_r, slope_start_r, slope_end_r, stab_cmd_r;

  // sequence state
  lpurs_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [TW-1:0] attempts_r, attempts_nxt;
  logic [CW-1:0] command_r, command_nxt;
  logic          done_r, done_nxt;
  logic          fault_nxt;

  // request and arithmetic registers
  logic                                   en_r;
  logic signed [lpurs_pkg::PROD_W-1:0]    prod_r;
  logic [lpurs_pkg::DVD_W-1:0]            dvd_r;
  logic [TW-1:0]                          den_r;
  logic [TW-1:0]                          rem_r;
  logic                                   neg_r, den_zero_r, prod_neg_r;

  // output register
  logic          out_valid_r;
  logic [CW-1:0] out_cmd_r;
  logic          out_end_r;
  logic [lpurs_pkg::PHASE_W-1:0] out_phase_r;
  logic [TW-1:0] out_ticks_r, out_att_r;
  logic          out_fault_r;

  // ramp arithmetic signals
  logic [TW-1:0]                       timer_inc;
  logic signed [lpurs_pkg::DIFF_W-1:0] diff;
  logic signed [lpurs_pkg::NUM_W-1:0]  num;
  logic signed [lpurs_pkg::NUM_W-1:0]  den;
  logic signed [lpurs_pkg::NUM_W-1:0]  den_abs;
  logic signed [lpurs_pkg::PROD_W-1:0] diff_x, num_x, prod_mag;
  logic [TW:0]                         shifted;
  logic                                q_bit;
  logic signed [lpurs_pkg::SUM_W-1:0]  quo_s, sum;
  logic [CW-1:0]                       ramp_cmd;
  logic                                ramp_end;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_time_r   <= '0;
      slope_time_r  <= '0;
      stab_time_r   <= '0;
      attempt_thr_r <= '0;
      init_cmd_r    <= '0;
      slope_start_r <= '0;
      slope_end_r   <= '0;
      stab_cmd_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpurs_pkg::REG_INIT_TIME:   init_time_r   <= cfg_wdata[TW-1:0];
        lpurs_pkg::REG_SLOPE_TIME:  slope_time_r  <= cfg_wdata[TW-1:0];
        lpurs_pkg::REG_STAB_TIME:   stab_time_r   <= cfg_wdata[TW-1:0];
        lpurs_pkg::REG_ATTEMPT_THR: attempt_thr_r <= cfg_wdata[TW-1:0];
        lpurs_pkg::REG_INIT_CMD:    init_cmd_r    <= cfg_wdata;
        lpurs_pkg::REG_SLOPE_START: slope_start_r <= cfg_wdata;
        lpurs_pkg::REG_SLOPE_END:   slope_end_r   <= cfg_wdata;
        lpurs_pkg::REG_STAB_CMD:    stab_cmd_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ramp operands and product; the ramp point uses the timer after its step
  assign timer_inc = timer_r + 1'b1;
  assign diff   = $signed({1'b0, slope_end_r}) - $signed({1'b0, slope_start_r});
  assign num    = $signed({1'b0, timer_inc}) - $signed({1'b0, init_time_r});
  assign den    = $signed({1'b0, slope_time_r}) - $signed({1'b0, init_time_r});
  assign den_abs = den[lpurs_pkg::NUM_W-1] ? -den : den;
  assign diff_x = {{(lpurs_pkg::PROD_W-lpurs_pkg::DIFF_W){diff[lpurs_pkg::DIFF_W-1]}}, diff};
  assign num_x  = {{(lpurs_pkg::PROD_W-lpurs_pkg::NUM_W){num[lpurs_pkg::NUM_W-1]}}, num};
  assign prod_mag = prod_r[lpurs_pkg::PROD_W-1] ? -prod_r : prod_r;

  // restoring divide step
  assign shifted = {rem_r, dvd_r[lpurs_pkg::DVD_W-1]};
  assign q_bit   = (shifted >= {1'b0, den_r});

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.latch_en) en_r <= in_unlock_enable;
    if (cmd.mul_load) prod_r <= diff_x * num_x;
    if (cmd.div_load) begin
      dvd_r      <= prod_mag[lpurs_pkg::DVD_W-1:0];
      rem_r      <= '0;
      den_r      <= den_abs[TW-1:0];
      neg_r      <= prod_r[lpurs_pkg::PROD_W-1] ^ den[lpurs_pkg::NUM_W-1];
      prod_neg_r <= prod_r[lpurs_pkg::PROD_W-1];
      den_zero_r <= (den == '0);
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? TW'(shifted - {1'b0, den_r}) : shifted[TW-1:0];
      dvd_r <= {dvd_r[lpurs_pkg::DVD_W-2:0], q_bit};
    end
  end

  // signed quotient plus start, clamped
  assign quo_s = neg_r ? -$signed({2'b00, dvd_r}) : $signed({2'b00, dvd_r});
  assign sum   = quo_s + $signed({{(lpurs_pkg::SUM_W-CW){1'b0}}, slope_start_r});

  always_comb begin
    if (den_zero_r) begin
      ramp_cmd = prod_neg_r ? '0 : lpurs_pkg::CMD_MAX;
    end else if (sum < 0) begin
      ramp_cmd = '0;
    end else if (sum > $signed({{(lpurs_pkg::SUM_W-CW){1'b0}}, lpurs_pkg::CMD_MAX})) begin
      ramp_cmd = lpurs_pkg::CMD_MAX;
    end else begin
      ramp_cmd = sum[CW-1:0];
    end
  end

  assign ramp_end       = (timer_r >= slope_time_r);
  assign sts.need_ramp  = en_r && (phase_r == lpurs_pkg::PH_RAMP) && !ramp_end;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // sequence update for one request
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    attempts_nxt = attempts_r;
    command_nxt  = command_r;
    done_nxt     = done_r;
    fault_nxt    = 1'b0;
    unique case (phase_r)
      lpurs_pkg::PH_IDLE: begin
        if (en_r) begin
          done_nxt     = 1'b0;
          attempts_nxt = '0;
          phase_nxt    = lpurs_pkg::PH_INIT;
          command_nxt  = init_cmd_r;
          timer_nxt    = '0;
        end
      end
      lpurs_pkg::PH_INIT: begin
        if (!en_r) begin
          attempts_nxt = '0;
          done_nxt     = 1'b1;
          phase_nxt    = lpurs_pkg::PH_IDLE;
        end else begin
          if (timer_r >= init_time_r) begin
            phase_nxt   = lpurs_pkg::PH_RAMP;
            command_nxt = slope_start_r;
          end
          if (timer_r != lpurs_pkg::CNT_MAX) timer_nxt = timer_r + 1'b1;
        end
      end
      lpurs_pkg::PH_RAMP: begin
        if (!en_r) begin
          attempts_nxt = '0;
          done_nxt     = 1'b1;
          phase_nxt    = lpurs_pkg::PH_IDLE;
        end else if (ramp_end) begin
          if (timer_r != lpurs_pkg::CNT_MAX) timer_nxt = timer_r + 1'b1;
          phase_nxt   = lpurs_pkg::PH_STAB;
          command_nxt = stab_cmd_r;
          if (attempts_r != lpurs_pkg::CNT_MAX) attempts_nxt = attempts_r + 1'b1;
        end else begin
          timer_nxt   = timer_r + 1'b1;
          command_nxt = ramp_cmd;
        end
      end
      lpurs_pkg::PH_STAB: begin
        if (!en_r) begin
          attempts_nxt = '0;
          done_nxt     = 1'b1;
          phase_nxt    = lpurs_pkg::PH_IDLE;
        end else if (timer_r >= stab_time_r) begin
          if (attempts_r >= attempt_thr_r) begin
            phase_nxt = lpurs_pkg::PH_END;
            done_nxt  = 1'b1;
          end else begin
            phase_nxt   = lpurs_pkg::PH_INIT;
            command_nxt = init_cmd_r;
            timer_nxt   = '0;
          end
        end else begin
          timer_nxt = timer_r + 1'b1;
        end
      end
      lpurs_pkg::PH_END: phase_nxt = lpurs_pkg::PH_IDLE;
      default: begin
        phase_nxt = lpurs_pkg::PH_IDLE;
        fault_nxt = 1'b1;
      end
    endcase
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lpurs_pkg::PH_IDLE;
      timer_r    <= '0;
      attempts_r <= '0;
      command_r  <= '0;
      done_r     <= 1'b0;
    end else if (cmd.commit) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      attempts_r <= attempts_nxt;
      command_r  <= command_nxt;
      done_r     <= done_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_cmd_r   <= command_nxt;
      out_end_r   <= done_nxt;
      out_phase_r <= phase_nxt;
      out_ticks_r <= timer_nxt;
      out_att_r   <= attempts_nxt;
      out_fault_r <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_command = out_cmd_r;
  assign out_end_flag      = out_end_r;
  assign out_phase_code    = out_phase_r;
  assign out_phase_ticks   = out_ticks_r;
  assign out_attempts_done = out_att_r;
  assign out_phase_fault   = out_fault_r;

endmodule

@@ rtl/lock_pin_unlock_ramp_sequencer.sv @@
// top level of the lock-pin unlock ramp sequencer
// depends on lpurs_pkg, lpurs_ctrl and lpurs_dp
//
// Usage:
//   Input channel in_valid/in_stall carries one tick request with the
//   unlock enable bit. Output channel out_valid/out_stall returns one
//   result per request: drive command, end flag, phase code, tick count,
//   attempt count and phase fault, all as they stand after the tick.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the
//   user writes it only while no request is in flight; the block leaves that to the user.
//   A request that does not compute a ramp point goes from acceptance
//   through decode to done, where its result is loaded; a ramp point
//   also passes load and the restoring divider: 18 quotient bits, one a cycle.
//   One request is in flight at a time; the next is accepted the cycle
//   after the previous result is loaded into the output register.
//   If the receiver stalls, the result holds in the output register; one
//   more request can be accepted and worked up to its final step, which
//   waits until the output register is free.
//   Reset (rst_n low, synchronous) clears the configuration to zero, puts
//   the sequence in idle with timer, attempts, command and end flag zero.
module lock_pin_unlock_ramp_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lpurs_pkg::IDX_W-1:0]        cfg_index,
  input  logic [lpurs_pkg::CMD_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_unlock_enable,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lpurs_pkg::CMD_W-1:0]        out_drive_command,
  output logic                               out_end_flag,
  output logic [lpurs_pkg::PHASE_W-1:0]      out_phase_code,
  output logic [lpurs_pkg::TICK_W-1:0]       out_phase_ticks,
  output logic [lpurs_pkg::TICK_W-1:0]       out_attempts_done,
  output logic                               out_phase_fault
);

  lpurs_pkg::dp_cmd_t cmd;
  lpurs_pkg::dp_sts_t sts;

  // controller
  lpurs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  lpurs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_unlock_enable  (in_unlock_enable),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_command (out_drive_command),
    .out_end_flag      (out_end_flag),
    .out_phase_code    (out_phase_code),
    .out_phase_ticks   (out_phase_ticks),
    .out_attempts_done (out_attempts_done),
    .out_phase_fault   (out_phase_fault)
  );

  // a result is only loaded when the output register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result loaded over a pending result");

  // an accepted request blocks the input until its result is loaded
  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while one is in flight");

  // a loaded result shows up as valid
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("loaded result not presented");

  // divider only steps while a request is in flight
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> in_stall)
    else $error("divider stepping with input open");

endmodule
